@@ rtl/core/assert_macros.svh @@
// assertion helpers for the slot table sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSL_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PSL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/psl_pkg.sv @@
package psl_pkg;

    localparam int PSL_SLOTS = 32;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_ADVANCE  = 3'd2;
    localparam logic [2:0] CMD_READ_AT  = 3'd3;
    localparam logic [2:0] CMD_READ_CUR = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_occupied;
        logic [30:0] entry_id;
        logic [63:0] entry_start;
        logic [5:0]  process_count;
        logic [4:0]  current_slot;
    } t_result;

    typedef struct packed {
        logic        en;
        logic        used;
        logic [30:0] id;
        logic [63:0] start;
    } t_store_wr;

    typedef struct packed {
        logic        used;
        logic [30:0] id;
        logic [63:0] start;
    } t_store_rd;

endpackage

@@ rtl/core/psl_cmd_if.sv @@
interface psl_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [30:0] proc_id;
    logic [63:0] start_time;
    logic [4:0]  slot_index;

    modport source (output valid, command, proc_id, start_time, slot_index, input ready);
    modport sink   (input valid, command, proc_id, start_time, slot_index, output ready);
endinterface

@@ rtl/core/psl_res_if.sv @@
interface psl_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        entry_occupied;
    logic [30:0] entry_id;
    logic [63:0] entry_start;
    logic [5:0]  process_count;
    logic [4:0]  current_slot;

    modport source (output valid, status, entry_occupied, entry_id, entry_start,
                    process_count, current_slot, input ready);
    modport sink   (input valid, status, entry_occupied, entry_id, entry_start,
                    process_count, current_slot, output ready);
endinterface

@@ rtl/core/process_slot_table.sv @@
// channel | dir | words                                          | accepted when
// i_cmd   | in  | command, proc_id, start_time, slot_index       | valid && ready
// o_res   | out | status, entry_*, process_count, current_slot   | valid && ready
//
// Add, remove and advance scan one slot per cycle through the slot memory
// read port. Reads check a single slot; advance on an empty table and unused
// commands skip the scan.
// Synchronous active-low reset empties the table; no clearing pass.
// A finished word waits in the output register while the next command is taken;
// a second finished word holds the sequencer until that register drains.
module process_slot_table
    import psl_pkg::*;
#(
    parameter  int SLOTS = PSL_SLOTS,
    localparam int IW    = $clog2(SLOTS)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psl_cmd_if.sink   i_cmd,
    psl_res_if.source o_res
);

    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;
    t_store_wr     w_wr;
    t_store_rd     w_rd;

    psl_seq #(.SLOTS(SLOTS)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr),
        .o_wr      (w_wr),
        .i_rd      (w_rd)
    );

    psl_store #(.SLOTS(SLOTS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr      (w_wr),
        .o_rd      (w_rd)
    );

endmodule

@@ rtl/core/psl_match.sv @@
module psl_match
    import psl_pkg::*;
(
    input  logic [2:0]  i_cmd,
    input  logic [30:0] i_pid,
    input  t_store_rd   i_rd,
    output logic        o_hit
);

    always_comb begin
        unique case (i_cmd)
            CMD_ADD:     o_hit = !i_rd.used;
            CMD_REMOVE:  o_hit = i_rd.used && (i_rd.id == i_pid);
            CMD_ADVANCE: o_hit = i_rd.used;
            default:     o_hit = 1'b1;
        endcase
    end

endmodule

@@ rtl/core/psl_store.sv @@
module psl_store
    import psl_pkg::*;
#(
    parameter  int SLOTS = PSL_SLOTS,
    localparam int IW    = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  t_store_wr     i_wr,
    output t_store_rd     o_rd
);

    logic [SLOTS-1:0] r_used;
    logic [30:0]      r_mem_id    [SLOTS];
    logic [63:0]      r_mem_start [SLOTS];
    t_store_rd        r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_wr_addr] <= i_wr.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_id[i_wr_addr]    <= i_wr.id;
            r_mem_start[i_wr_addr] <= i_wr.start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd.used  <= r_used[i_rd_addr];
        r_rd.id    <= r_mem_id[i_rd_addr];
        r_rd.start <= r_mem_start[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

@@ rtl/core/psl_seq.sv @@
module psl_seq
    import psl_pkg::*;
#(
    parameter  int SLOTS = PSL_SLOTS,
    localparam int IW    = $clog2(SLOTS),
    localparam int CW    = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psl_cmd_if.sink       i_cmd,
    psl_res_if.source     o_res,
    output logic [IW-1:0] o_rd_addr,
    output logic [IW-1:0] o_wr_addr,
    output t_store_wr     o_wr,
    input  t_store_rd     i_rd
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state        r_state;
    logic [2:0]    r_cmd;
    logic [30:0]   r_pid;
    logic [63:0]   r_start;
    logic [IW-1:0] r_base;
    logic          r_oob;
    logic [IW-1:0] r_k;
    logic          r_chk;
    logic [IW-1:0] r_chk_addr;
    logic          r_chk_last;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_ptr;
    t_result       r_res;
    t_result       r_out;
    logic          r_ov;

    logic [IW:0]   w_sum;
    logic [IW-1:0] w_addr;
    logic          w_hit;
    logic          w_end;
    logic          w_rd_cmd;
    logic          w_show;
    logic [CW-1:0] w_cnt_nx;
    logic [IW-1:0] w_ptr_nx;
    logic [1:0]    w_status;
    logic          w_accept;
    logic          w_oob_in;
    logic [IW+4:0] w_idx_ext;
    logic [CW+5:0] w_cnt_ext;
    logic [CW+5:0] w_cnt_cur_ext;
    logic [IW+4:0] w_ptr_ext;
    logic [IW+4:0] w_ptr_cur_ext;

    psl_match u_match (
        .i_cmd (r_cmd),
        .i_pid (r_pid),
        .i_rd  (i_rd),
        .o_hit (w_hit)
    );

    // circular slot address: base plus step, wrapped once
    assign w_sum  = {1'b0, r_base} + {1'b0, r_k};
    assign w_addr = (w_sum >= (IW+1)'(SLOTS)) ? IW'(w_sum - (IW+1)'(SLOTS)) : w_sum[IW-1:0];
    assign o_rd_addr = w_addr;

    assign w_end    = (r_state == S_SCAN) && r_chk && (w_hit || r_chk_last);
    assign w_rd_cmd = (r_cmd == CMD_READ_AT) || (r_cmd == CMD_READ_CUR);
    assign w_show   = w_rd_cmd && !r_oob && i_rd.used;

    always_comb begin
        w_cnt_nx = r_count;
        w_ptr_nx = r_ptr;
        w_status = ST_OK;
        if (r_cmd == CMD_ADD) begin
            if (w_hit) w_cnt_nx = r_count + CW'(1);
            else       w_status = ST_FULL;
        end else if (r_cmd == CMD_REMOVE) begin
            if (w_hit) w_cnt_nx = r_count - CW'(1);
            else       w_status = ST_NOT_FOUND;
        end else if (r_cmd == CMD_ADVANCE) begin
            if (w_hit) w_ptr_nx = r_chk_addr;
        end
    end

    assign w_cnt_ext     = {6'd0, w_cnt_nx};
    assign w_cnt_cur_ext = {6'd0, r_count};
    assign w_ptr_ext     = {5'd0, w_ptr_nx};
    assign w_ptr_cur_ext = {5'd0, r_ptr};
    assign w_idx_ext     = {{IW{1'b0}}, i_cmd.slot_index};
    assign w_oob_in      = w_idx_ext >= (IW+5)'(SLOTS);

    assign o_wr.en    = w_end && w_hit && ((r_cmd == CMD_ADD) || (r_cmd == CMD_REMOVE));
    assign o_wr.used  = (r_cmd == CMD_ADD);
    assign o_wr.id    = (r_cmd == CMD_ADD) ? r_pid : '0;
    assign o_wr.start = (r_cmd == CMD_ADD) ? r_start : '0;
    assign o_wr_addr  = r_chk_addr;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_chk   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_ov || o_res.ready)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_cmd.command;
                        r_pid   <= i_cmd.proc_id;
                        r_start <= i_cmd.start_time;
                        r_k     <= '0;
                        r_chk   <= 1'b0;
                        r_oob   <= (i_cmd.command == CMD_READ_AT) && w_oob_in;
                        if (i_cmd.command == CMD_READ_AT) begin
                            r_base <= w_oob_in ? '0 : w_idx_ext[IW-1:0];
                        end else if ((i_cmd.command == CMD_READ_CUR) ||
                                     (i_cmd.command == CMD_ADVANCE)) begin
                            r_base <= r_ptr;
                        end else begin
                            r_base <= '0;
                        end
                        if ((i_cmd.command == CMD_ADD) || (i_cmd.command == CMD_REMOVE) ||
                            (i_cmd.command == CMD_READ_AT) ||
                            (i_cmd.command == CMD_READ_CUR) ||
                            ((i_cmd.command == CMD_ADVANCE) && (r_count != '0))) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_res.status         <= ST_OK;
                            r_res.entry_occupied <= 1'b0;
                            r_res.entry_id       <= '0;
                            r_res.entry_start    <= '0;
                            r_res.process_count  <= w_cnt_cur_ext[5:0];
                            r_res.current_slot   <= w_ptr_cur_ext[4:0];
                            r_state              <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_k        <= r_k + IW'(1);
                    r_chk      <= !w_end;
                    r_chk_addr <= w_addr;
                    r_chk_last <= (r_k == IW'(SLOTS - 1));
                    if (w_end) begin
                        r_count              <= w_cnt_nx;
                        r_ptr                <= w_ptr_nx;
                        r_res.status         <= w_status;
                        r_res.entry_occupied <= w_show;
                        r_res.entry_id       <= w_show ? i_rd.id : '0;
                        r_res.entry_start    <= w_show ? i_rd.start : '0;
                        r_res.process_count  <= w_cnt_ext[5:0];
                        r_res.current_slot   <= w_ptr_ext[4:0];
                        r_state              <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.status         = r_out.status;
    assign o_res.entry_occupied = r_out.entry_occupied;
    assign o_res.entry_id       = r_out.entry_id;
    assign o_res.entry_start    = r_out.entry_start;
    assign o_res.process_count  = r_out.process_count;
    assign o_res.current_slot   = r_out.current_slot;

    `PSL_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_count <= CW'(SLOTS), "count beyond table size")
    `PSL_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state == S_DONE), "word shown outside done")
    `PSL_ASSERT(a_wr_on_check, i_clk, i_rst_n, o_wr.en |-> (r_state == S_SCAN && r_chk), "write without checked slot")
    `PSL_ASSERT(a_oob_read_at, i_clk, i_rst_n, (r_state == S_SCAN && r_oob) |-> (r_cmd == CMD_READ_AT), "out of range flag on wrong command")
    `PSL_ASSERT_NEXT(a_done_after_wr, i_clk, i_rst_n, o_wr.en, r_state == S_DONE, "scan did not stop on write")

endmodule

@@ dv/process_slot_table_test.sv @@
`timescale 1ns / 100ps

module process_slot_table_test;
    import psl_pkg::*;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          DRAIN_CYCLES  = PSL_SLOTS + 8;
    localparam int          RANDOM_WORDS  = 1800;
    localparam int          PHASE_WORDS   = 150;
    localparam logic [2:0]  CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;
    localparam logic [30:0] ID_MAX        = 31'h7fff_ffff;

    typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} idle_phase_t;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} load_mix_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [30:0] proc_id;
        logic [63:0] start_time;
        logic [4:0]  slot_index;
    } cmd_word_t;

    logic i_clk;
    logic i_rst_n;

    psl_cmd_if cmd_if ();
    psl_res_if res_if ();

    process_slot_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // predicted table contents
    logic        tbl_used  [PSL_SLOTS];
    logic [30:0] tbl_id    [PSL_SLOTS];
    logic [63:0] tbl_start [PSL_SLOTS];
    logic [5:0]  tbl_count;
    logic [4:0]  tbl_ptr;

    cmd_word_t   pending_cmds[$];
    t_result     expected_results[$];
    logic [30:0] added_ids[$];
    logic [30:0] id_pool[16];
    cmd_word_t   next_word;
    int          words_sent;
    int          errors;
    int          cycles;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_result table_apply(input logic [2:0] op, input logic [30:0] pid,
                                            input logic [63:0] start, input logic [4:0] idx);
        t_result    r;
        logic [4:0] p;
        logic       done;
        r        = '0;
        r.status = ST_OK;
        done     = 1'b0;
        case (op)
            CMD_ADD: begin
                r.status = ST_FULL;
                for (int i = 0; i < PSL_SLOTS; i++) begin
                    if (!done && !tbl_used[i]) begin
                        tbl_used[i]  = 1'b1;
                        tbl_id[i]    = pid;
                        tbl_start[i] = start;
                        tbl_count    = tbl_count + 1'b1;
                        r.status     = ST_OK;
                        done         = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < PSL_SLOTS; i++) begin
                    if (!done && tbl_used[i] && tbl_id[i] == pid) begin
                        tbl_used[i]  = 1'b0;
                        tbl_id[i]    = '0;
                        tbl_start[i] = '0;
                        if (tbl_count > 0) tbl_count = tbl_count - 1'b1;
                        r.status     = ST_OK;
                        done         = 1'b1;
                    end
                end
            end
            CMD_ADVANCE: begin
                if (tbl_count > 0) begin
                    p = tbl_ptr;
                    for (int i = 0; i < PSL_SLOTS; i++) begin
                        if (!done && tbl_used[p]) begin
                            tbl_ptr = p;
                            done    = 1'b1;
                        end
                        p = p + 1'b1;
                    end
                end
            end
            CMD_READ_AT: begin
                r.entry_occupied = tbl_used[idx];
                r.entry_id       = tbl_id[idx];
                r.entry_start    = tbl_start[idx];
            end
            CMD_READ_CUR: begin
                r.entry_occupied = tbl_used[tbl_ptr];
                r.entry_id       = tbl_id[tbl_ptr];
                r.entry_start    = tbl_start[tbl_ptr];
            end
            default: ;
        endcase
        r.process_count = tbl_count;
        r.current_slot  = tbl_ptr;
        return r;
    endfunction

    function automatic idle_phase_t idle_phase();
        return idle_phase_t'((words_sent / PHASE_WORDS) % 4);
    endfunction

    function automatic logic sender_gap();
        case (idle_phase())
            PH_SEND_GAPS: return $urandom_range(0, 99) < 76;
            PH_BOTH:      return $urandom_range(0, 99) < 10;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (idle_phase())
            PH_RECV_STALLS: return $urandom_range(0, 99) < 76;
            PH_BOTH:        return $urandom_range(0, 99) < 10;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h (word %0d)", what, got, want, words_sent);
        errors++;
    endtask

    task automatic queue_word(input logic [2:0] op, input logic [30:0] pid,
                              input logic [63:0] start, input logic [4:0] idx);
        pending_cmds.push_back('{command: op, proc_id: pid, start_time: start,
                                 slot_index: idx});
    endtask

    function automatic logic [63:0] pick_start();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [30:0] pick_id();
        if ($urandom_range(0, 3) == 0) return 31'($urandom);
        return id_pool[$urandom_range(0, 15)];
    endfunction

    task automatic queue_random_words();
        load_mix_t   mix;
        int          left;
        int          add_pct;
        int          rem_pct;
        int          r;
        logic [30:0] pid;
        left = 0;
        mix  = MIX_BALANCED;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (left == 0) begin
                mix  = load_mix_t'($urandom_range(0, 2));
                left = $urandom_range(60, 120);
            end
            left--;
            add_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 10 : 30;
            rem_pct = (mix == MIX_DRAIN) ? 60 : (mix == MIX_FILL) ? 10 : 25;
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                pid = pick_id();
                added_ids.push_back(pid);
                queue_word(CMD_ADD, pid, pick_start(), 5'($urandom));
            end else if (r < add_pct + rem_pct) begin
                if (added_ids.size() > 0 && $urandom_range(0, 9) < 8) begin
                    pid = added_ids.pop_front();
                end else begin
                    pid = pick_id();
                end
                queue_word(CMD_REMOVE, pid, pick_start(), 5'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    queue_word(CMD_ADVANCE, pick_id(), pick_start(), 5'($urandom));
                end else if (r < 65) begin
                    queue_word(CMD_READ_AT, pick_id(), pick_start(), 5'($urandom));
                end else if (r < 90) begin
                    queue_word(CMD_READ_CUR, pick_id(), pick_start(), 5'($urandom));
                end else begin
                    queue_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), pick_id(),
                               pick_start(), 5'($urandom));
                end
            end
        end
    endtask

    // command driver; the table is predicted as each word is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (cmd_if.valid) begin
                expected_results.push_back(table_apply(cmd_if.command, cmd_if.proc_id,
                                                       cmd_if.start_time, cmd_if.slot_index));
                words_sent <= words_sent + 1;
            end
            if (pending_cmds.size() > 0 && !sender_gap()) begin
                next_word = pending_cmds.pop_front();
                cmd_if.command    <= next_word.command;
                cmd_if.proc_id    <= next_word.proc_id;
                cmd_if.start_time <= next_word.start_time;
                cmd_if.slot_index <= next_word.slot_index;
                cmd_if.valid      <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !receiver_stall();
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, status", res_if.status, '0);
            end else begin
                want = expected_results.pop_front();
                if (res_if.status !== want.status)
                    report_mismatch("status", res_if.status, want.status);
                if (res_if.entry_occupied !== want.entry_occupied)
                    report_mismatch("entry_occupied", res_if.entry_occupied,
                                    want.entry_occupied);
                if (res_if.entry_id !== want.entry_id)
                    report_mismatch("entry_id", res_if.entry_id, want.entry_id);
                if (res_if.entry_start !== want.entry_start)
                    report_mismatch("entry_start", res_if.entry_start, want.entry_start);
                if (res_if.process_count !== want.process_count)
                    report_mismatch("process_count", res_if.process_count,
                                    want.process_count);
                if (res_if.current_slot !== want.current_slot)
                    report_mismatch("current_slot", res_if.current_slot, want.current_slot);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [30:0] rnd_id;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_ADD;
        cmd_if.proc_id    = '0;
        cmd_if.start_time = '0;
        cmd_if.slot_index = '0;
        res_if.ready      = 1'b0;
        words_sent        = 0;
        errors            = 0;
        cycles            = 0;
        for (int i = 0; i < PSL_SLOTS; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_id[i]    = '0;
            tbl_start[i] = '0;
        end
        tbl_count = '0;
        tbl_ptr   = '0;

        id_pool[0] = '0;
        id_pool[1] = ID_MAX;
        for (int i = 2; i < 16; i++) id_pool[i] = 31'($urandom);
        rnd_id = 31'($urandom);

        // empty table: reads, advance in place, remove of id 0 must not hit cleared slots
        queue_word(CMD_READ_CUR, '0, '0, '0);
        queue_word(CMD_READ_AT, '0, '0, 5'd0);
        queue_word(CMD_READ_AT, '0, '0, 5'd31);
        queue_word(CMD_ADVANCE, '0, '0, '0);
        queue_word(CMD_REMOVE, '0, '0, '0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            queue_word(3'(c), ID_MAX, '1, 5'd31);
        queue_word(CMD_ADD, ID_MAX, '1, 5'd31);
        queue_word(CMD_ADD, '0, '0, '0);
        queue_word(CMD_ADD, rnd_id, {$urandom, $urandom}, '0);
        queue_word(CMD_READ_AT, '0, '0, 5'd0);
        queue_word(CMD_READ_AT, '0, '0, 5'd1);
        queue_word(CMD_READ_AT, '0, '0, 5'd2);
        queue_word(CMD_READ_CUR, '0, '0, '0);
        queue_word(CMD_REMOVE, '0, '0, '0);
        queue_word(CMD_REMOVE, ID_MAX, '0, '0);
        queue_word(CMD_ADVANCE, '0, '0, '0);
        queue_word(CMD_READ_CUR, '0, '0, '0);
        queue_word(CMD_REMOVE, ~rnd_id, '0, '0);
        queue_word(CMD_REMOVE, rnd_id, '0, '0);
        queue_word(CMD_ADVANCE, '0, '0, '0);
        queue_word(CMD_READ_CUR, '0, '0, '0);
        queue_random_words();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || cmd_if.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
